[rtl/adjmg_pkg.sv]
// Shared types, codes and helper functions for the adjacency matrix graph block.
package adjmg_pkg;

    // Graph size and derived widths
    localparam int VERTICES = 64;
    localparam int ADDR_W   = $clog2(VERTICES);
    localparam int VERTEX_W = 6;
    localparam int ACTION_W = 2;

    // Request action codes as seen on the input stream
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LIST  = 2'd2;

    // Command kinds after classification
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_LIST  = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // Command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [VERTICES-1:0] row_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } cmd_t;

    typedef struct packed {
        logic                status;
        logic                is_adjacent;
        logic [VERTEX_W-1:0] neighbor;
        logic                found;
        logic                last;
    } res_t;

    // Single set bit at the given column
    function automatic row_t col_bit(input logic [ADDR_W-1:0] idx);
        row_t r;
        r = '0;
        r[idx] = 1'b1;
        return r;
    endfunction

    // Index of the lowest set bit (zero when the row is empty)
    function automatic logic [ADDR_W-1:0] first_set(input row_t r);
        logic [ADDR_W-1:0] idx;
        idx = '0;
        for (int i = VERTICES - 1; i >= 0; i--) begin
            if (r[i]) begin
                idx = ADDR_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/adjacency_matrix_graph.sv]
// Adjacency matrix graph: top level joining front end, command queue and back end.
//
// Undirected graph of 64 vertices kept as a 64 x 64 bit matrix.
// Input stream s_axis: tuser carries the action (add edge, query, list
// neighbours), tdata carries vertex_a and vertex_b. Unused action codes are
// taken and dropped without a result.
// Output stream m_axis: tdata carries status, is_adjacent, neighbor and found;
// tlast marks the final result of each request.
// Requests pass through a two-entry command queue to a sequencer that runs
// one request at a time against the matrix memory (one write port, two
// registered read ports). Steps per request, queue to result register:
// add edge reads both rows, then writes row a and row b; query reads, then
// checks both bits; out-of-range goes straight to the result; list reads
// row a, loads it, then scans at one result per cycle while output is free.
// Reset clears all control state and every row valid bit at once, so the
// graph is empty from the first cycle; the input holds tready low for one
// cycle after reset. A stalled receiver holds the result register; the
// sequencer waits, then the queue fills and tready drops.
module adjacency_matrix_graph
    import adjmg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [5:0] vertex_a, [11:6] vertex_b, zero pad
    input  logic [ACTION_W-1:0] s_axis_tuser,   // [1:0] action
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [0] status, [1] is_adjacent,
                                                // [7:2] neighbor, [8] found, zero pad
    output logic                m_axis_tlast
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_head;
    res_t res;

    // Request classification
    adjmg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_action   (s_axis_tuser),
        .s_vertex_a (s_axis_tdata[VERTEX_W-1:0]),
        .s_vertex_b (s_axis_tdata[2*VERTEX_W-1:VERTEX_W]),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    // Command queue
    adjmg_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Execution and result register
    adjmg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_res       (res)
    );

    // Output packing
    assign m_axis_tdata = {7'd0, res.found, res.neighbor, res.is_adjacent, res.status};
    assign m_axis_tlast = res.last;

endmodule

[rtl/adjmg_front.sv]
// Front end: accepts input requests, range checks and classifies them into commands.
module adjmg_front
    import adjmg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [VERTEX_W-1:0] s_vertex_a,
    input  logic [VERTEX_W-1:0] s_vertex_b,
    output logic                push,
    output cmd_t                push_cmd,
    input  logic                q_full
);

    logic a_ok;
    logic b_ok;
    logic known;
    logic busy_reg;
    logic busy_next;

    // Ready whenever the queue has room; reset holds the port off for one cycle
    always_comb begin
        busy_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign s_ready = !q_full && !busy_reg;

    // Range checks against the vertex count
    assign a_ok  = (32'(s_vertex_a) < VERTICES);
    assign b_ok  = (32'(s_vertex_b) < VERTICES);
    assign known = (s_action == ACT_ADD) || (s_action == ACT_QUERY) ||
                   (s_action == ACT_LIST);

    // Unused action codes are dropped here and never reach the back end
    assign push = s_valid && s_ready && known;

    // Classify the request
    always_comb begin
        push_cmd.a = s_vertex_a[ADDR_W-1:0];
        push_cmd.b = s_vertex_b[ADDR_W-1:0];
        unique case (s_action)
            ACT_ADD:   push_cmd.kind = (a_ok && b_ok) ? KIND_ADD : KIND_ERR;
            ACT_QUERY: push_cmd.kind = (a_ok && b_ok) ? KIND_QUERY : KIND_ERR;
            ACT_LIST:  push_cmd.kind = a_ok ? KIND_LIST : KIND_ERR;
            default:   push_cmd.kind = KIND_ERR;
        endcase
    end

endmodule

[rtl/adjmg_cmd_fifo.sv]
// Short command queue between the front end and the execution back end.
module adjmg_cmd_fifo
    import adjmg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (32'(count_reg) == QDEPTH);
    assign not_empty = (count_reg != '0);
    assign head      = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/adjmg_back.sv]
// Back end: holds the adjacency matrix, runs commands and drives the result register.
module adjmg_back
    import adjmg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic q_not_empty,
    input  cmd_t q_head,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_ADD_A = 3'd2;
    localparam logic [2:0] ST_ADD_B = 3'd3;
    localparam logic [2:0] ST_QUERY = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;
    localparam logic [2:0] ST_SCAN  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // Matrix rows; a row not yet written reads as empty via its valid bit
    row_t                mem [VERTICES];
    logic [VERTICES-1:0] row_vld_reg;
    logic [VERTICES-1:0] row_vld_next;
    row_t                rd_a_reg;
    row_t                rd_b_reg;
    logic                rd_va_reg;
    logic                rd_vb_reg;
    row_t                row_a;
    row_t                row_b;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    row_t                mem_wdata;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    cmd_t                cmd_reg;
    cmd_t                cmd_next;
    row_t                scan_reg;
    row_t                scan_next;
    res_t                pend_reg;
    res_t                pend_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    res_t                m_res_reg;
    res_t                m_res_next;

    logic                slot_free;
    logic                load;
    res_t                load_res;
    logic [ADDR_W-1:0]   nb_idx;
    row_t                scan_rest;

    assign row_a     = rd_a_reg & {VERTICES{rd_va_reg}};
    assign row_b     = rd_b_reg & {VERTICES{rd_vb_reg}};
    assign slot_free = !m_valid_reg || m_ready;
    assign nb_idx    = first_set(scan_reg);
    assign scan_rest = scan_reg & ~col_bit(nb_idx);

    // Matrix memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg  <= mem[cmd_reg.a];
        rd_b_reg  <= mem[cmd_reg.b];
        rd_va_reg <= row_vld_reg[cmd_reg.a];
        rd_vb_reg <= row_vld_reg[cmd_reg.b];
    end

    // Command sequencer
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        row_vld_next = row_vld_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cmd_reg.a;
        mem_wdata    = row_a | col_bit(cmd_reg.b);
        load         = 1'b0;
        load_res     = pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    if (q_head.kind == KIND_ERR) begin
                        pend_next  = '{status: 1'b1, is_adjacent: 1'b0, neighbor: '0,
                                       found: 1'b0, last: 1'b1};
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                unique case (cmd_reg.kind)
                    KIND_ADD:   state_next = ST_ADD_A;
                    KIND_QUERY: state_next = ST_QUERY;
                    default:    state_next = ST_LOAD;
                endcase
            end
            ST_ADD_A: begin
                mem_we                  = 1'b1;
                mem_waddr               = cmd_reg.a;
                mem_wdata               = row_a | col_bit(cmd_reg.b);
                row_vld_next[cmd_reg.a] = 1'b1;
                state_next              = ST_ADD_B;
            end
            ST_ADD_B: begin
                mem_we                  = 1'b1;
                mem_waddr               = cmd_reg.b;
                mem_wdata               = row_b | col_bit(cmd_reg.a);
                row_vld_next[cmd_reg.b] = 1'b1;
                pend_next  = '{status: 1'b0, is_adjacent: 1'b0, neighbor: '0,
                               found: 1'b0, last: 1'b1};
                state_next = ST_OUT;
            end
            ST_QUERY: begin
                pend_next  = '{status: 1'b0,
                               is_adjacent: row_a[cmd_reg.b] && row_b[cmd_reg.a],
                               neighbor: '0, found: 1'b0, last: 1'b1};
                state_next = ST_OUT;
            end
            ST_LOAD: begin
                // Own vertex is never reported
                scan_next  = row_a & ~col_bit(cmd_reg.a);
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (slot_free) begin
                    load = 1'b1;
                    if (scan_reg == '0) begin
                        load_res   = '{status: 1'b0, is_adjacent: 1'b0, neighbor: '0,
                                       found: 1'b0, last: 1'b1};
                        state_next = ST_IDLE;
                    end else begin
                        load_res   = '{status: 1'b0, is_adjacent: 1'b0,
                                       neighbor: VERTEX_W'(nb_idx), found: 1'b1,
                                       last: (scan_rest == '0)};
                        scan_next  = scan_rest;
                        if (scan_rest == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    load       = 1'b1;
                    load_res   = pend_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register, parts the sequencer from the output stall
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_res_next   = load_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_vld_reg <= row_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        scan_reg  <= scan_next;
        pend_reg  <= pend_next;
        m_res_reg <= m_res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule
